>>> hdl/nrf_pkg.sv
package nrf_pkg;

  // Defaults for the top-level parameters
  localparam int ENTRIES_DEF     = 16;
  localparam int NONCE_CHARS_DEF = 16;

  // Fixed field geometry
  localparam int MAX_CHARS  = 16;  // bytes carried by the two nonce words
  localparam int NONCE_W    = 64;
  localparam int WINDOW_W   = 40;
  localparam int TIME_W     = 47;
  localparam int MSG_TIME_W = 48;
  localparam int DIFF_W     = 50;  // holds now - msg_time without overflow

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 40'd120;
  localparam logic [TIME_W-1:0]   SYNC_RESET   = 47'd1704067200;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 47;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC   = 2'd1;

  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_MALFORMED = 2'd1,
    VERDICT_WINDOW    = 2'd2,
    VERDICT_REPLAY    = 2'd3
  } verdict_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_LAST,
    ST_INSERT,
    ST_DONE
  } state_e;

  // Early checks from the screening stage
  typedef struct packed {
    logic malformed;
    logic outside;
  } screen_t;

endpackage

>>> hdl/nonce_replay_filter.sv
// Flow: an accepted message passes PREP, SCAN over every cache entry, then LAST; a new
//   nonce then goes through INSERT, a replay skips it, and a malformed or out-of-window message goes from PREP to DONE.
// Throughput: one message at a time; the next input transaction is taken only after DONE,
//   which waits on the cache walk (one entry per cycle, single RAM read port) and on the
//   output register draining before the result is loaded.
// Reset: async active low; cache empty, slot 0, window 120 s, sync threshold 1704067200.
module nonce_replay_filter #(
  parameter int ENTRIES     = nrf_pkg::ENTRIES_DEF,
  parameter int NONCE_CHARS = nrf_pkg::NONCE_CHARS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // message input
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [nrf_pkg::NONCE_W-1:0]           nonce_low_i,
  input  logic [nrf_pkg::NONCE_W-1:0]           nonce_high_i,
  input  logic                                  well_formed_i,
  input  logic signed [nrf_pkg::MSG_TIME_W-1:0] message_time_i,
  input  logic [nrf_pkg::TIME_W-1:0]            current_time_i,
  // verdict output
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  accepted_o,
  output logic [1:0]                            verdict_o,
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [nrf_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [nrf_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int RAM_W  = 2 * nrf_pkg::NONCE_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

  nrf_pkg::state_e state_q, state_d;

  // config registers
  logic [nrf_pkg::WINDOW_W-1:0] window_q;
  logic [nrf_pkg::TIME_W-1:0]   sync_q;

  // cache bookkeeping: valid bits live in flops, nonces in the RAM
  logic [ENTRIES-1:0] used_q;
  logic [SLOT_W-1:0]  slot_q;

  // scan pipeline: address issued, then compared in the next cycle
  logic [SLOT_W-1:0]  scan_idx_q;
  logic               cmp_vld_q;
  logic [SLOT_W-1:0]  cmp_idx_q;
  logic               hit_q;
  logic               cur_hit;

  nrf_pkg::verdict_e  verdict_q;
  logic               out_valid_q;
  nrf_pkg::verdict_e  out_verdict_q;

  // strobes from the output decode
  logic accept;
  logic scan_rd;
  logic ins_we;
  logic out_load;

  logic [RAM_W-1:0]  nonce;
  logic [RAM_W-1:0]  rdata;
  nrf_pkg::screen_t  screen;

  nrf_screen #(
    .NONCE_CHARS (NONCE_CHARS)
  ) u_screen (
    .clk_i          (clk_i),
    .load_i         (accept),
    .nonce_low_i    (nonce_low_i),
    .nonce_high_i   (nonce_high_i),
    .well_formed_i  (well_formed_i),
    .message_time_i (message_time_i),
    .current_time_i (current_time_i),
    .window_i       (window_q),
    .sync_i         (sync_q),
    .nonce_o        (nonce),
    .screen_o       (screen)
  );

  nrf_ram #(
    .WIDTH (RAM_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ins_we),
    .waddr_i (slot_q),
    .wdata_i (nonce),
    .re_i    (scan_rd),
    .raddr_i (scan_idx_q),
    .rdata_o (rdata)
  );

  // Entries never written are masked by their valid bit, so stale RAM data
  // never produces a hit.
  assign cur_hit = cmp_vld_q && used_q[cmp_idx_q] && (rdata == nonce);

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nrf_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = nrf_pkg::ST_PREP;
      end
      nrf_pkg::ST_PREP: begin
        // early rejects skip the cache walk
        if (screen.malformed || screen.outside) state_d = nrf_pkg::ST_DONE;
        else state_d = nrf_pkg::ST_SCAN;
      end
      nrf_pkg::ST_SCAN: begin
        if (scan_idx_q == LAST_SLOT) state_d = nrf_pkg::ST_LAST;
      end
      nrf_pkg::ST_LAST: begin
        // last compare lands here
        if (hit_q || cur_hit) state_d = nrf_pkg::ST_DONE;
        else state_d = nrf_pkg::ST_INSERT;
      end
      nrf_pkg::ST_INSERT: begin
        state_d = nrf_pkg::ST_DONE;
      end
      nrf_pkg::ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) state_d = nrf_pkg::ST_IDLE;
      end
      default: state_d = nrf_pkg::ST_IDLE;
    endcase
  end

  // ---------------- output decode ----------------
  always_comb begin
    in_stall_o = 1'b1;
    scan_rd    = 1'b0;
    ins_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      nrf_pkg::ST_IDLE:   in_stall_o = 1'b0;
      nrf_pkg::ST_PREP:   ;
      nrf_pkg::ST_SCAN:   scan_rd = 1'b1;
      nrf_pkg::ST_LAST:   ;
      nrf_pkg::ST_INSERT: ins_we = 1'b1;
      nrf_pkg::ST_DONE:   out_load = !out_valid_q || !out_stall_i;
      default:            ;
    endcase
  end

  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nrf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // config writes; indexes past the register list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= nrf_pkg::WINDOW_RESET;
      sync_q   <= nrf_pkg::SYNC_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        nrf_pkg::REG_WINDOW: window_q <= cfg_data_i[nrf_pkg::WINDOW_W-1:0];
        nrf_pkg::REG_SYNC:   sync_q   <= cfg_data_i[nrf_pkg::TIME_W-1:0];
        default:             ;
      endcase
    end
  end

  // scan control and verdict tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      hit_q      <= 1'b0;
      verdict_q  <= nrf_pkg::VERDICT_OK;
    end else begin
      cmp_vld_q <= scan_rd;
      cmp_idx_q <= scan_idx_q;
      if (state_q == nrf_pkg::ST_PREP) begin
        scan_idx_q <= '0;
        hit_q      <= 1'b0;
        if (screen.malformed) verdict_q <= nrf_pkg::VERDICT_MALFORMED;
        else if (screen.outside) verdict_q <= nrf_pkg::VERDICT_WINDOW;
        else verdict_q <= nrf_pkg::VERDICT_OK;
      end else begin
        if (scan_rd && scan_idx_q != LAST_SLOT) scan_idx_q <= scan_idx_q + 1'b1;
        if (cur_hit) hit_q <= 1'b1;
        if (state_q == nrf_pkg::ST_LAST && (hit_q || cur_hit)) begin
          verdict_q <= nrf_pkg::VERDICT_REPLAY;
        end
      end
    end
  end

  // insert: mark entry valid, advance the round-robin pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      slot_q <= '0;
    end else if (ins_we) begin
      used_q[slot_q] <= 1'b1;
      slot_q         <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
    end
  end

  // output register: holds one verdict while the next message is taken in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_verdict_q <= verdict_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = out_verdict_q;
  assign accepted_o  = (out_verdict_q == nrf_pkg::VERDICT_OK);

endmodule

>>> hdl/nrf_ram.sv
module nrf_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/nrf_screen.sv
module nrf_screen #(
  parameter int NONCE_CHARS = nrf_pkg::NONCE_CHARS_DEF
) (
  input  logic                              clk_i,
  input  logic                              load_i,
  input  logic [nrf_pkg::NONCE_W-1:0]       nonce_low_i,
  input  logic [nrf_pkg::NONCE_W-1:0]       nonce_high_i,
  input  logic                              well_formed_i,
  input  logic signed [nrf_pkg::MSG_TIME_W-1:0] message_time_i,
  input  logic [nrf_pkg::TIME_W-1:0]        current_time_i,
  input  logic [nrf_pkg::WINDOW_W-1:0]      window_i,
  input  logic [nrf_pkg::TIME_W-1:0]        sync_i,
  output logic [2*nrf_pkg::NONCE_W-1:0]     nonce_o,
  output nrf_pkg::screen_t                  screen_o
);

  localparam int NB = nrf_pkg::MAX_CHARS;
  localparam int DW = nrf_pkg::DIFF_W;

  logic [2*nrf_pkg::NONCE_W-1:0] raw;
  logic [2*nrf_pkg::NONCE_W-1:0] canon;
  logic [NB:0]                   keep;  // keep[i]: bytes 0..i all nonzero
  logic                          malformed;
  logic signed [DW-1:0]          diff_d;
  logic signed [DW-1:0]          win_s;

  logic [2*nrf_pkg::NONCE_W-1:0] nonce_q;
  logic                          malformed_q;
  logic                          synced_q;
  logic signed [DW-1:0]          diff_q;

  assign raw = {nonce_high_i, nonce_low_i};

  always_comb begin
    keep     = '0;
    canon    = '0;
    keep[0]  = (raw[7:0] != 8'd0);
    for (int i = 1; i < NB; i++) begin
      keep[i] = keep[i-1] && (raw[8*i +: 8] != 8'd0);
    end
    keep[NB] = 1'b0;  // no byte past the last one
    for (int i = 0; i < NB; i++) begin
      canon[8*i +: 8] = keep[i] ? raw[8*i +: 8] : 8'd0;
    end
  end

  // empty, too long, or flagged bad upstream
  assign malformed = !well_formed_i || !keep[0] || keep[NONCE_CHARS];

  assign diff_d = $signed({{(DW-nrf_pkg::TIME_W){1'b0}}, current_time_i})
                - $signed({{(DW-nrf_pkg::MSG_TIME_W){message_time_i[nrf_pkg::MSG_TIME_W-1]}},
                           message_time_i});

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      nonce_q     <= canon;
      malformed_q <= malformed;
      synced_q    <= (current_time_i > sync_i);
      diff_q      <= diff_d;
    end
  end

  assign win_s = $signed({{(DW-nrf_pkg::WINDOW_W){1'b0}}, window_i});

  assign nonce_o            = nonce_q;
  assign screen_o.malformed = malformed_q;
  assign screen_o.outside   = synced_q && ((diff_q > win_s) || (diff_q < -win_s));

endmodule

>>> bench/nonce_replay_filter_tb.sv
module nonce_replay_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NONCE_W         = nrf_pkg::NONCE_W;
  localparam int MSG_TIME_W      = nrf_pkg::MSG_TIME_W;
  localparam int TIME_W          = nrf_pkg::TIME_W;
  localparam int WINDOW_W        = nrf_pkg::WINDOW_W;
  localparam int CFG_IDX_W       = nrf_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W      = nrf_pkg::CFG_DATA_W;
  localparam int MAX_CHARS       = nrf_pkg::MAX_CHARS;
  localparam int ENTRIES_DEF     = nrf_pkg::ENTRIES_DEF;
  localparam int NONCE_CHARS_DEF = nrf_pkg::NONCE_CHARS_DEF;

  localparam logic [WINDOW_W-1:0]  WINDOW_RESET = nrf_pkg::WINDOW_RESET;
  localparam logic [TIME_W-1:0]    SYNC_RESET   = nrf_pkg::SYNC_RESET;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = nrf_pkg::REG_WINDOW;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC     = nrf_pkg::REG_SYNC;

  typedef nrf_pkg::verdict_e verdict_e;

  // Register indexes that decode to nothing; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam logic [TIME_W-1:0]   TIME_MAX   = '1;
  localparam logic [WINDOW_W-1:0] WINDOW_MAX = '1;
  localparam longint SYNC_L = longint'(SYNC_RESET);

  // Long receiver hold-off used to back the block up into its input.
  localparam int HOLD_CYCLES = 200;

  typedef struct {
    logic [NONCE_W-1:0]           lo;
    logic [NONCE_W-1:0]           hi;
    logic                         wf;
    logic signed [MSG_TIME_W-1:0] mt;
    logic [TIME_W-1:0]            now;
  } message_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                         in_valid;
  logic                         in_stall;
  logic [NONCE_W-1:0]           nonce_low;
  logic [NONCE_W-1:0]           nonce_high;
  logic                         well_formed;
  logic signed [MSG_TIME_W-1:0] message_time;
  logic [TIME_W-1:0]            current_time;
  logic                         out_valid;
  logic                         out_stall;
  logic                         accepted;
  logic [1:0]                   verdict;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;

  // Shared control between the test tasks and the receiver process.
  logic calm     = 1'b0;  // no gaps, no stalls
  logic hold_req = 1'b0;  // ask the receiver for one long hold-off

  int errors = 0;

  // Mirror of the block: configuration, nonce cache and round-robin pointer.
  logic [WINDOW_W-1:0] window_cfg;
  logic [TIME_W-1:0]   sync_cfg;
  logic                cache_used [ENTRIES_DEF];
  logic [127:0]        cache_nonce[ENTRIES_DEF];
  int                  cache_slot;

  // Verdicts owed by the block, oldest first.
  verdict_e pending_verdicts[$];

  // Raw nonces seen recently, reused to provoke replays.
  logic [127:0] recent_nonces[$];
  int unsigned  serial = 1;

  nonce_replay_filter dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .nonce_low_i    (nonce_low),
    .nonce_high_i   (nonce_high),
    .well_formed_i  (well_formed),
    .message_time_i (message_time),
    .current_time_i (current_time),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .accepted_o     (accepted),
    .verdict_o      (verdict),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Verdict predictor
  // ---------------------------------------------------------------------

  // Works out the verdict for one accepted message and commits the nonce to
  // the mirrored cache when the message gets through.
  function automatic verdict_e judge_message(input message_t m);
    logic [127:0] raw;
    logic [127:0] canon;
    int           len;
    longint       diff;
    longint       lim;
    verdict_e     v;
    raw = {m.hi, m.lo};
    // The string ends at its first NUL; whatever follows is ignored.
    len = MAX_CHARS;
    for (int i = MAX_CHARS - 1; i >= 0; i--) begin
      if (raw[8*i +: 8] == 8'h00) len = i;
    end
    canon = (len == MAX_CHARS) ? raw : raw & ((128'd1 << (8 * len)) - 128'd1);

    v = nrf_pkg::VERDICT_OK;
    if (!m.wf || len == 0 || len > NONCE_CHARS_DEF) begin
      v = nrf_pkg::VERDICT_MALFORMED;
    end else if (m.now > sync_cfg) begin
      // 64-bit signed arithmetic covers the 47-bit minus 48-bit difference.
      diff = longint'(m.now) - longint'(m.mt);
      lim  = longint'(window_cfg);
      if (diff > lim || diff < -lim) v = nrf_pkg::VERDICT_WINDOW;
    end

    if (v == nrf_pkg::VERDICT_OK) begin
      for (int i = 0; i < ENTRIES_DEF; i++) begin
        if (cache_used[i] && cache_nonce[i] == canon) v = nrf_pkg::VERDICT_REPLAY;
      end
    end

    if (v == nrf_pkg::VERDICT_OK) begin
      cache_used[cache_slot]  = 1'b1;
      cache_nonce[cache_slot] = canon;
      cache_slot = (cache_slot + 1) % ENTRIES_DEF;
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic message_t msg(input logic [NONCE_W-1:0] lo,
                                   input logic [NONCE_W-1:0] hi,
                                   input logic wf,
                                   input logic signed [MSG_TIME_W-1:0] mt,
                                   input logic [TIME_W-1:0] now);
    message_t m;
    m.lo  = lo;
    m.hi  = hi;
    m.wf  = wf;
    m.mt  = mt;
    m.now = now;
    return m;
  endfunction

  // Unique printable-ish nonce, every byte nonzero, high word empty.
  function automatic logic [NONCE_W-1:0] serial_nonce();
    logic [NONCE_W-1:0] v;
    v = {32'h2B2B_2B2B, 1'b1, serial[27:21], 1'b1, serial[20:14],
         1'b1, serial[13:7], 1'b1, serial[6:0]};
    serial++;
    return v;
  endfunction

  // len nonzero characters, a NUL, then junk or zeros.
  function automatic logic [127:0] rand_nonce(input int len, input bit junk);
    logic [127:0] v;
    v = '0;
    for (int i = 0; i < MAX_CHARS; i++) begin
      if (i < len)      v[8*i +: 8] = 8'($urandom_range(1, 255));
      else if (i > len) v[8*i +: 8] = junk ? 8'($urandom_range(0, 255)) : 8'h00;
    end
    return v;
  endfunction

  function automatic logic [63:0] rand_below(input logic [63:0] n);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return (n == 64'd0) ? 64'd0 : r % (n + 64'd1);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // One input transaction. Valid is left high when no gap follows, so the
  // next call simply replaces the payload at the next falling edge.
  task automatic send_message(input message_t m);
    int gap;
    @(negedge clk);
    in_valid     = 1'b1;
    nonce_low    = m.lo;
    nonce_high   = m.hi;
    well_formed  = m.wf;
    message_time = m.mt;
    current_time = m.now;
    do @(posedge clk); while (in_stall);
    pending_verdicts.push_back(judge_message(m));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid, let every owed verdict come back, then a little slack.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (ENTRIES_DEF + 6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WINDOW: window_cfg = data[WINDOW_W-1:0];
      REG_SYNC:   sync_cfg   = data[TIME_W-1:0];
      default: ;  // unmapped index, nothing changes
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------

  initial begin : receiver_stall
    int burst;
    int r;
    burst     = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
        out_stall = 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_stall = 1'b1;
      end else if (calm) begin
        out_stall = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall = 1'b0;
        end else if (r < 95) begin
          out_stall = 1'b1;
          burst     = $urandom_range(0, 2);
        end else begin
          out_stall = 1'b1;
          burst     = $urandom_range(10, 30);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checking: every result transaction against the oldest verdict
  // ---------------------------------------------------------------------

  always @(posedge clk) begin : verdict_check
    verdict_e want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with nothing outstanding, verdict", verdict, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (accepted !== (want == nrf_pkg::VERDICT_OK))
          report_mismatch("accepted", accepted, want == nrf_pkg::VERDICT_OK);
        if (verdict !== want)
          report_mismatch("verdict", verdict, want);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Default registers: window 120 s, threshold SYNC_RESET.
  task automatic test_directed();
    calm = 1'b1;
    // not well formed, then an empty nonce with junk in the high word
    send_message(msg(64'h6261, 64'h0, 1'b0, 48'sd0, SYNC_RESET));
    send_message(msg(64'h0, '1, 1'b1, 48'sd0, SYNC_RESET));
    // full 16 characters at the extremes; clock not synced yet
    send_message(msg('1, '1, 1'b1, 48'sh8000_0000_0000, SYNC_RESET));
    send_message(msg('1, '1, 1'b1, 48'sh7FFF_FFFF_FFFF, 47'd0));
    // junk after the NUL must not count: "A" then a clean "A"
    send_message(msg(64'hDEAD_BEEF_00C3_0041, 64'h0123_4567_89AB_CDEF, 1'b1,
                     48'sd0, 47'd5));
    send_message(msg(64'h41, 64'h0, 1'b1, 48'sd0, 47'd5));
    // eight characters, terminator at the start of the high word
    send_message(msg(64'h0102_0304_0506_0708, 64'hFFFF_FFFF_FFFF_FF00, 1'b1,
                     48'sd0, 47'd0));
    send_message(msg(64'h0102_0304_0506_0708, 64'h0, 1'b1, 48'sd0, 47'd0));
    calm = 1'b0;
    // window edges just past the threshold
    send_message(msg(64'h3177, 64'h0, 1'b1, MSG_TIME_W'(SYNC_L + 1 + 120),
                     SYNC_RESET + 1));
    send_message(msg(64'h3277, 64'h0, 1'b1, MSG_TIME_W'(SYNC_L + 1 - 120),
                     SYNC_RESET + 1));
    send_message(msg(64'h3377, 64'h0, 1'b1, MSG_TIME_W'(SYNC_L + 1 + 121),
                     SYNC_RESET + 1));
    send_message(msg(64'h3477, 64'h0, 1'b1, MSG_TIME_W'(SYNC_L + 1 - 121),
                     SYNC_RESET + 1));
    // widest possible difference, and zero difference at the top of range
    send_message(msg(64'h3577, 64'h0, 1'b1, 48'sh8000_0000_0000, TIME_MAX));
    send_message(msg(64'h3677, 64'h0, 1'b1, 48'sh7FFF_FFFF_FFFF, TIME_MAX));
    // exactly at the threshold the window is not applied
    send_message(msg(64'h3777, 64'h0, 1'b1, 48'sh8000_0000_0000, SYNC_RESET));
    // out-of-window rejection left no trace: the same nonce now goes in
    send_message(msg(64'h3377, 64'h0, 1'b1, MSG_TIME_W'(SYNC_L + 1), SYNC_RESET + 1));
    // malformed wins over replay, window wins over replay
    send_message(msg(64'h3377, 64'h0, 1'b0, MSG_TIME_W'(SYNC_L + 1), SYNC_RESET + 1));
    send_message(msg(64'h3377, 64'h0, 1'b1, 48'sd0, SYNC_RESET + 1));
    send_message(msg(64'h3377, 64'h0, 1'b1, MSG_TIME_W'(SYNC_L + 1), SYNC_RESET + 1));
  endtask

  task automatic test_config();
    wait_idle();
    write_reg(REG_WINDOW, '0);
    write_reg(REG_SYNC, '0);
    send_message(msg(serial_nonce(), 64'h0, 1'b1, 48'sd1, 47'd1));
    send_message(msg(serial_nonce(), 64'h0, 1'b1, 48'sd0, 47'd1));
    send_message(msg(serial_nonce(), 64'h0, 1'b1, -48'sd5, 47'd0));
    wait_idle();
    // bits above the window width are dropped; threshold at its top
    write_reg(REG_WINDOW, '1);
    write_reg(REG_SYNC, TIME_MAX);
    send_message(msg(serial_nonce(), 64'h0, 1'b1, 48'sh8000_0000_0000, TIME_MAX));
    wait_idle();
    write_reg(REG_SYNC, '0);
    // writes to unmapped indexes must leave both registers alone
    write_reg(REG_SPARE_LO, '0);
    write_reg(REG_SPARE_HI, 47'h1234_5678_9ABC);
    send_message(msg(serial_nonce(), 64'h0, 1'b1,
                     MSG_TIME_W'(longint'(TIME_MAX) - longint'(WINDOW_MAX)), TIME_MAX));
    send_message(msg(serial_nonce(), 64'h0, 1'b1,
                     MSG_TIME_W'(longint'(TIME_MAX) - longint'(WINDOW_MAX) - 1),
                     TIME_MAX));
    wait_idle();
    write_reg(REG_WINDOW, CFG_DATA_W'(WINDOW_RESET));
    write_reg(REG_SYNC, SYNC_RESET);
  endtask

  // Overrun the 16 slots, then replay both evicted and live nonces.
  task automatic test_cache_wrap();
    logic [NONCE_W-1:0] seen[$];
    for (int i = 0; i < ENTRIES_DEF + 4; i++) begin
      seen.push_back(serial_nonce());
      send_message(msg(seen[i], 64'h0, 1'b1, 48'sd0, 47'd0));
    end
    for (int i = 0; i < 4; i++)
      send_message(msg(seen[i], 64'h0, 1'b1, 48'sd0, 47'd0));
    for (int i = ENTRIES_DEF + 3; i >= ENTRIES_DEF - 2; i--)
      send_message(msg(seen[i], 64'h0, 1'b1, 48'sd0, 47'd0));
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    wait_idle();
    hold_req = 1'b1;
    calm     = 1'b1;
    for (int i = 0; i < 8; i++)
      send_message(msg(serial_nonce(), 64'h0, 1'b1, 48'sd0, 47'd0));
    calm = 1'b0;
  endtask

  function automatic message_t random_message();
    message_t     m;
    logic [127:0] raw;
    logic [63:0]  span;
    logic [63:0]  tmp;
    longint       w;
    longint       off;
    int           r;
    r = $urandom_range(0, 99);
    m.wf = ($urandom_range(0, 19) != 0);
    if (r < 55 || recent_nonces.size() == 0) begin
      raw = rand_nonce($urandom_range(1, MAX_CHARS), $urandom_range(0, 1));
      recent_nonces.push_back(raw);
      if (recent_nonces.size() > 32) void'(recent_nonces.pop_front());
    end else if (r < 85) begin
      raw = recent_nonces[$urandom_range(0, recent_nonces.size() - 1)];
    end else begin
      case ($urandom_range(0, 2))
        0:       raw = rand_nonce(0, 1'b1);
        1:       raw = {$urandom, $urandom, $urandom, $urandom};
        default: raw = rand_nonce($urandom_range(1, MAX_CHARS), 1'b1);
      endcase
    end
    m.lo = raw[63:0];
    m.hi = raw[127:64];

    // Mostly past the threshold so the window check gets exercised.
    r = $urandom_range(0, 99);
    if (r < 60 && sync_cfg != TIME_MAX) begin
      span = 64'(TIME_MAX - sync_cfg) - 64'd1;
      if ($urandom_range(0, 3) != 0 && span > 64'd1000) span = 64'd1000;
      tmp = 64'(sync_cfg) + 64'd1 + rand_below(span);
    end else if (r < 85) begin
      tmp = rand_below(64'(sync_cfg));
    end else begin
      tmp = {$urandom, $urandom};
    end
    m.now = tmp[TIME_W-1:0];

    // Message time as an offset from now: inside, on the edges, or anywhere.
    w = longint'(window_cfg);
    r = $urandom_range(0, 99);
    if (r < 80) begin
      if (r < 50) begin
        off = longint'(rand_below(64'(2 * w))) - w;
      end else begin
        case ($urandom_range(0, 3))
          0:       off = w;
          1:       off = -w;
          2:       off = w + 1;
          default: off = -w - 1;
        endcase
      end
      tmp = 64'(longint'(m.now) - off);
    end else begin
      tmp = {$urandom, $urandom};
    end
    m.mt = tmp[MSG_TIME_W-1:0];
    return m;
  endfunction

  // Five register settings, about two hundred messages under each.
  task automatic test_random();
    logic [WINDOW_W-1:0] win;
    logic [TIME_W-1:0]   thr;
    logic [63:0]         tmp;
    for (int phase = 0; phase < 5; phase++) begin
      tmp = {$urandom, $urandom};
      case (phase)
        0: begin win = WINDOW_RESET; thr = SYNC_RESET; end
        1: begin win = '0; thr = '0; end
        2: begin win = WINDOW_MAX; thr = '0; end
        3: begin win = WINDOW_W'($urandom_range(0, 1000)); thr = tmp[TIME_W-1:0]; end
        default: begin win = tmp[WINDOW_W-1:0]; thr = TIME_MAX; end
      endcase
      wait_idle();
      write_reg(REG_WINDOW, CFG_DATA_W'(win));
      write_reg(REG_SYNC, thr);
      for (int i = 0; i < 200; i++) begin
        // Some fifty-message stretches run with no idling at all.
        if (i % 50 == 0) calm = ($urandom_range(0, 4) == 0);
        send_message(random_message());
      end
      calm = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    nonce_low    = '0;
    nonce_high   = '0;
    well_formed  = 1'b0;
    message_time = '0;
    current_time = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_WINDOW;
    cfg_data     = '0;

    window_cfg = WINDOW_RESET;
    sync_cfg   = SYNC_RESET;
    cache_slot = 0;
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      cache_used[i]  = 1'b0;
      cache_nonce[i] = '0;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_config();
    test_cache_wrap();
    test_backpressure();
    test_random();

    // Drain; a missing verdict ends in the watchdog below.
    wait_idle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: ends the run if the sequence hangs.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
